[rtl/core/obve_pkg.sv]
// ----------------------------------------------------------------------------
// obve_pkg: oriented box vertex expander package
// Shared constants, codes and the vertex-to-corner table.
// ----------------------------------------------------------------------------
package obve_pkg;

  localparam int BOXES_PER_BATCH_DEF = 128;
  localparam int VERTS_PER_BOX       = 24;
  localparam int REG_IDX_W           = 2;
  localparam int DIV_STEPS           = 48;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HALF_WIDTH  = 2'd0,
    REG_HALF_DEPTH  = 2'd1,
    REG_HALF_LENGTH = 2'd2,
    REG_NORM_EN     = 2'd3
  } obve_reg_e;

  typedef enum logic [1:0] {
    VEC_DIR   = 2'd0,
    VEC_SIDE1 = 2'd1,
    VEC_SIDE2 = 2'd2
  } obve_vec_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SQ     = 3'd1,
    ST_SQRT   = 3'd2,
    ST_DIV    = 3'd3,
    ST_CROSS1 = 3'd4,
    ST_CROSS2 = 3'd5,
    ST_TERMS  = 3'd6,
    ST_EMIT   = 3'd7
  } obve_state_e;

  // corners 0..3 on the base, 4..7 on top
  localparam logic [2:0] CORNER_TAB [VERTS_PER_BOX] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd6, 3'd5, 3'd4,
    3'd0, 3'd4, 3'd5, 3'd1, 3'd1, 3'd5, 3'd6, 3'd2,
    3'd2, 3'd6, 3'd7, 3'd3, 3'd3, 3'd7, 3'd4, 3'd0
  };

  localparam logic [31:0] HALF_RESET    = 32'h0001_0000;
  localparam logic [63:0] SQRT_BIT_INIT = 64'h4000_0000_0000_0000;

endpackage

[rtl/core/oriented_box_vertex_expander_unit.sv]
// ----------------------------------------------------------------------------
// oriented_box_vertex_expander_unit
// Expands one oriented box into 24 quad vertices with normals and indices.
// ----------------------------------------------------------------------------
// One box is taken at a time and yields 24 vertex transfers. With
// normalization off a box goes through the cross product, nine scaling
// products, then one vertex per cycle; with it on, each of three vectors
// also goes through the squared length on the shared 33x33 multiplier,
// a one-bit-per-cycle square root and a 48-step divider per component.
// Output backpressure stalls vertex emission.
module oriented_box_vertex_expander_unit #(
  parameter int BOXES_PER_BATCH = obve_pkg::BOXES_PER_BATCH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [obve_pkg::REG_IDX_W-1:0] cfg_addr_i,
  input  logic [31:0]                    cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // center_x, center_y, center_z, axis_x, axis_y, axis_z
  input  logic [191:0]                   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // vert_x/y/z, normal_x/y/z, tex_u, tex_v, vertex_index, 2 pad bits
  output logic [207:0]                   m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import obve_pkg::*;

  localparam int BoxW = (BOXES_PER_BATCH > 1) ? $clog2(BOXES_PER_BATCH) : 1;
  localparam int IdxW = (BoxW + 5 > 12) ? BoxW + 5 : 12;
  localparam logic signed [65:0] SatMax = 66'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [65:0] SatMin = -66'sh0_0000_0000_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SatMax) r = 32'sh7FFF_FFFF;
    else if (v < SatMin) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] negsat(input logic signed [31:0] a);
    logic signed [31:0] r;
    r = (a == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -a;
    return r;
  endfunction

  // config
  logic signed [31:0] hw_q, hd_q, hl_q;
  logic               norm_en_q;

  // control
  obve_state_e        state_q, state_d;
  logic [3:0]         step_q, step_d;
  logic               ph_q, ph_d;
  obve_vec_e          nv_q, nv_d;
  logic [1:0]         comp_q, comp_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [4:0]         vtx_q, vtx_d;
  logic [BoxW-1:0]    box_q, box_d;
  logic               out_valid_q, out_valid_d;

  // datapath
  logic signed [31:0] p_q [3];
  logic signed [31:0] dir_q [3], dir_d [3];
  logic signed [31:0] s1v_q [3], s1v_d [3];
  logic signed [31:0] s2v_q [3], s2v_d [3];
  logic [63:0]        sq_q, sq_d, root_q, root_d, bit_q, bit_d;
  logic [31:0]        rem_q, rem_d;
  logic [47:0]        num_q, num_d;
  logic signed [65:0] acc_q, acc_d;
  logic signed [49:0] term_q [9], term_d [9];
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  // output register
  logic signed [31:0] ov_q [3], on_q [3];
  logic               otu_q, otv_q, olast_q;
  logic [11:0]        oidx_q;
  logic signed [31:0] ev [3], en [3];
  logic [IdxW-1:0]    vidx_full;
  logic               out_load;

  logic signed [31:0] comp_val;
  logic signed [32:0] comp_mag;

  always_comb begin
    case (nv_q)
      VEC_DIR:   comp_val = dir_q[comp_q];
      VEC_SIDE1: comp_val = s1v_q[comp_q];
      default:   comp_val = s2v_q[comp_q];
    endcase
    comp_mag = comp_val[31] ? -33'(comp_val) : 33'(comp_val);
  end

  // shared multiplier, registered
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_comb begin
    logic [64:0]        trial;
    logic [32:0]        dtrial;
    logic               ge;
    logic signed [65:0] accn;
    logic signed [31:0] qval;
    logic signed [65:0] sh;
    state_d = state_q;
    step_d  = step_q;
    ph_d    = ph_q;
    nv_d    = nv_q;
    comp_d  = comp_q;
    cnt_d   = cnt_q;
    vtx_d   = vtx_q;
    box_d   = box_q;
    dir_d   = dir_q;
    s1v_d   = s1v_q;
    s2v_d   = s2v_q;
    sq_d    = sq_q;
    root_d  = root_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    num_d   = num_q;
    acc_d   = acc_q;
    term_d  = term_q;
    mul_a   = comp_mag;
    mul_b   = comp_mag;
    trial   = 65'({1'b0, root_q}) + 65'({1'b0, bit_q});
    dtrial  = {rem_q, num_q[47]};
    ge      = 1'b0;
    accn    = '0;
    qval    = '0;
    sh      = '0;
    s_axis_tready_o = 1'b0;
    out_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          dir_d[0] = s_axis_tdata_i[127:96];
          dir_d[1] = s_axis_tdata_i[159:128];
          dir_d[2] = s_axis_tdata_i[191:160];
          if (norm_en_q) begin
            state_d = ST_SQ;
            nv_d    = VEC_DIR;
            comp_d  = 2'd0;
            ph_d    = 1'b0;
            sq_d    = '0;
          end else begin
            state_d = ST_CROSS1;
          end
        end
      end

      ST_SQ: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          sq_d = sq_q + prod_q[63:0];
          ph_d = 1'b0;
          if (comp_q == 2'd2) begin
            state_d = ST_SQRT;
            root_d  = '0;
            bit_d   = SQRT_BIT_INIT;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end
      end

      ST_SQRT: begin
        if (bit_q != '0) begin
          if ({1'b0, sq_q} >= trial) begin
            sq_d   = sq_q - trial[63:0];
            root_d = (root_q >> 1) + bit_q;
          end else begin
            root_d = root_q >> 1;
          end
          bit_d = bit_q >> 2;
        end else if (root_q == '0) begin
          // zero length: vector kept as is
          comp_d = 2'd0;
          case (nv_q)
            VEC_DIR:   state_d = ST_CROSS1;
            VEC_SIDE1: begin
              nv_d = VEC_SIDE2; state_d = ST_SQ; ph_d = 1'b0; sq_d = '0;
            end
            default: begin
              state_d = ST_TERMS; step_d = '0; ph_d = 1'b0;
            end
          endcase
        end else begin
          state_d = ST_DIV;
          comp_d  = 2'd0;
          ph_d    = 1'b0;
        end
      end

      ST_DIV: begin
        if (!ph_q) begin
          num_d = {comp_mag[31:0], 16'h0000};
          rem_d = '0;
          cnt_d = '0;
          ph_d  = 1'b1;
        end else if (cnt_q != 6'(DIV_STEPS)) begin
          ge    = dtrial >= {1'b0, root_q[31:0]};
          rem_d = ge ? 32'(dtrial - {1'b0, root_q[31:0]}) : dtrial[31:0];
          num_d = {num_q[46:0], ge};
          cnt_d = cnt_q + 6'd1;
        end else begin
          if (comp_val[31]) qval = sat32(-66'(num_q));
          else qval = sat32(66'(num_q));
          case (nv_q)
            VEC_DIR:   dir_d[comp_q] = qval;
            VEC_SIDE1: s1v_d[comp_q] = qval;
            default:   s2v_d[comp_q] = qval;
          endcase
          ph_d = 1'b0;
          if (comp_q != 2'd2) begin
            comp_d = comp_q + 2'd1;
          end else begin
            comp_d = 2'd0;
            case (nv_q)
              VEC_DIR:   state_d = ST_CROSS1;
              VEC_SIDE1: begin
                nv_d = VEC_SIDE2; state_d = ST_SQ; sq_d = '0;
              end
              default: begin
                state_d = ST_TERMS; step_d = '0;
              end
            endcase
          end
        end
      end

      ST_CROSS1: begin
        // dir x (1,0,0) = (0, dir_z, -dir_y)
        s1v_d[0] = '0;
        s1v_d[1] = dir_q[2];
        s1v_d[2] = negsat(dir_q[1]);
        state_d  = ST_CROSS2;
        step_d   = '0;
        ph_d     = 1'b0;
      end

      ST_CROSS2: begin
        case (step_q)
          4'd0:    begin mul_a = 33'(s1v_q[1]); mul_b = 33'(dir_q[2]); end
          4'd1:    begin mul_a = 33'(s1v_q[2]); mul_b = 33'(dir_q[1]); end
          4'd2:    begin mul_a = 33'(s1v_q[2]); mul_b = 33'(dir_q[0]); end
          default: begin mul_a = 33'(s1v_q[1]); mul_b = 33'(dir_q[0]); end
        endcase
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          accn = ((step_q == 4'd1) ? acc_q : '0) +
                 ((step_q == 4'd1 || step_q == 4'd3) ? -prod_q : prod_q);
          acc_d = accn;
          case (step_q)
            4'd1:    s2v_d[0] = sat32(accn >>> 16);
            4'd2:    s2v_d[1] = sat32(accn >>> 16);
            4'd3:    s2v_d[2] = sat32(accn >>> 16);
            default: ;
          endcase
          if (step_q == 4'd3) begin
            step_d = '0;
            if (norm_en_q) begin
              state_d = ST_SQ; nv_d = VEC_SIDE1; comp_d = 2'd0; sq_d = '0;
            end else begin
              state_d = ST_TERMS;
            end
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end

      ST_TERMS: begin
        case (step_q)
          4'd0:    begin mul_a = 33'(s1v_q[0]); mul_b = 33'(hw_q); end
          4'd1:    begin mul_a = 33'(s1v_q[1]); mul_b = 33'(hw_q); end
          4'd2:    begin mul_a = 33'(s1v_q[2]); mul_b = 33'(hw_q); end
          4'd3:    begin mul_a = 33'(s2v_q[0]); mul_b = 33'(hd_q); end
          4'd4:    begin mul_a = 33'(s2v_q[1]); mul_b = 33'(hd_q); end
          4'd5:    begin mul_a = 33'(s2v_q[2]); mul_b = 33'(hd_q); end
          4'd6:    begin mul_a = 33'(dir_q[0]); mul_b = 33'(hl_q); end
          4'd7:    begin mul_a = 33'(dir_q[1]); mul_b = 33'(hl_q); end
          default: begin mul_a = 33'(dir_q[2]); mul_b = 33'(hl_q); end
        endcase
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          // top terms use twice the half length
          sh = (step_q >= 4'd6) ? (prod_q >>> 15) : (prod_q >>> 16);
          term_d[step_q] = sh[49:0];
          if (step_q == 4'd8) begin
            state_d = ST_EMIT;
            vtx_d   = '0;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end

      ST_EMIT: begin
        out_load = !out_valid_q || m_axis_tready_i;
        if (out_load) begin
          if (vtx_q == 5'(VERTS_PER_BOX - 1)) begin
            state_d = ST_IDLE;
            box_d   = (box_q == BoxW'(BOXES_PER_BATCH - 1)) ? '0 : box_q + 1'b1;
          end else begin
            vtx_d = vtx_q + 5'd1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // vertex position and normal for the current vertex
  always_comb begin
    logic [2:0]         corner;
    logic               pos1, pos2;
    logic signed [51:0] sum;
    corner = CORNER_TAB[vtx_q];
    pos1   = corner[0] ^ corner[1];
    pos2   = corner[1];
    for (int i = 0; i < 3; i++) begin
      sum = 52'(p_q[i])
          + (pos1 ? 52'(term_q[i]) : -52'(term_q[i]))
          + (pos2 ? 52'(term_q[i+3]) : -52'(term_q[i+3]))
          + (corner[2] ? 52'(term_q[i+6]) : 52'sd0);
      ev[i] = sat32(66'(sum));
    end
    case (vtx_q[4:2])
      3'd0: for (int i = 0; i < 3; i++) en[i] = negsat(dir_q[i]);
      3'd1: for (int i = 0; i < 3; i++) en[i] = dir_q[i];
      3'd2: for (int i = 0; i < 3; i++) en[i] = negsat(s2v_q[i]);
      3'd3: for (int i = 0; i < 3; i++) en[i] = s1v_q[i];
      3'd4: for (int i = 0; i < 3; i++) en[i] = s2v_q[i];
      default: for (int i = 0; i < 3; i++) en[i] = negsat(s1v_q[i]);
    endcase
    vidx_full = IdxW'(box_q) * IdxW'(VERTS_PER_BOX) + IdxW'(vtx_q);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      ph_q        <= 1'b0;
      nv_q        <= VEC_DIR;
      comp_q      <= '0;
      cnt_q       <= '0;
      vtx_q       <= '0;
      box_q       <= '0;
      out_valid_q <= 1'b0;
      hw_q        <= HALF_RESET;
      hd_q        <= HALF_RESET;
      hl_q        <= HALF_RESET;
      norm_en_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ph_q        <= ph_d;
      nv_q        <= nv_d;
      comp_q      <= comp_d;
      cnt_q       <= cnt_d;
      vtx_q       <= vtx_d;
      box_q       <= box_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (obve_reg_e'(cfg_addr_i))
          REG_HALF_WIDTH:  hw_q      <= cfg_wdata_i;
          REG_HALF_DEPTH:  hd_q      <= cfg_wdata_i;
          REG_HALF_LENGTH: hl_q      <= cfg_wdata_i;
          REG_NORM_EN:     norm_en_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      p_q[0] <= s_axis_tdata_i[31:0];
      p_q[1] <= s_axis_tdata_i[63:32];
      p_q[2] <= s_axis_tdata_i[95:64];
    end
    dir_q  <= dir_d;
    s1v_q  <= s1v_d;
    s2v_q  <= s2v_d;
    sq_q   <= sq_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    acc_q  <= acc_d;
    term_q <= term_d;
    if (out_load) begin
      ov_q    <= ev;
      on_q    <= en;
      otu_q   <= vtx_q[0] ^ vtx_q[1];
      otv_q   <= vtx_q[1];
      oidx_q  <= vidx_full[11:0];
      olast_q <= (vtx_q == 5'(VERTS_PER_BOX - 1));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {2'b00, oidx_q, otv_q, otu_q,
                            on_q[2], on_q[1], on_q[0], ov_q[2], ov_q[1], ov_q[0]};

  // a box in progress blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a box is in progress");

  // texture corner follows vertex number (per-box stride is a multiple of four)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[192] == (m_axis_tdata_o[194] ^ m_axis_tdata_o[195]))
                        && (m_axis_tdata_o[193] == m_axis_tdata_o[195]))
    else $error("texture coordinate does not match vertex index");

  // divider only runs on a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> root_q != '0)
    else $error("division by zero length");

endmodule

[tb/sv/obve_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obve_checker: vertex stream predictor and scoreboard
// Watches config writes and both streams, predicts the 24 vertices of
// every accepted box and compares each output transfer in order.
// ----------------------------------------------------------------------------
module obve_checker #(
  parameter int BOXES_PER_BATCH = obve_pkg::BOXES_PER_BATCH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [obve_pkg::REG_IDX_W-1:0] cfg_addr_i,
  input  logic [31:0]                    cfg_wdata_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [191:0]                   s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [207:0]                   m_tdata_i,
  input  logic                           m_tlast_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import obve_pkg::*;

  typedef logic signed [31:0] q_t;
  typedef logic signed [79:0] wide_t;
  typedef struct { q_t x, y, z; } vec_t;
  typedef struct {
    q_t          px, py, pz, nx, ny, nz;
    logic        u, v;
    logic [11:0] idx;
    logic        last;
  } vertex_t;

  vertex_t vertex_q[$];
  q_t      half_w, half_d, half_l;
  logic    norm_en;
  int      box_num;

  assign pending_o = vertex_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic q_t sat_q(wide_t v);
    if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -wide_t'(64'sd2147483648)) return 32'sh80000000;
    return q_t'(v);
  endfunction

  function automatic q_t neg_q(q_t a);
    return (a == 32'sh80000000) ? 32'sh7fffffff : -a;
  endfunction

  function automatic vec_t cross_q(vec_t a, vec_t b);
    vec_t r;
    wide_t ax, ay, az, bx, by, bz;
    ax = a.x; ay = a.y; az = a.z; bx = b.x; by = b.y; bz = b.z;
    r.x = sat_q((ay * bz - az * by) >>> 16);
    r.y = sat_q((az * bx - ax * bz) >>> 16);
    r.z = sat_q((ax * by - ay * bx) >>> 16);
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned sq);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'h4000_0000_0000_0000;
    while (bit_w > sq) bit_w >>= 2;
    while (bit_w != 0) begin
      if (sq >= res + bit_w) begin
        sq -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(q_t c);
    wide_t w;
    w = c;
    if (w < 0) w = -w;
    return longint'(w);
  endfunction

  function automatic q_t unit_comp(q_t c, longint unsigned len);
    longint unsigned q;
    q = (mag(c) << 16) / len;
    return (c < 0) ? sat_q(-wide_t'(q)) : sat_q(wide_t'(q));
  endfunction

  function automatic vec_t unit_vec(vec_t v);
    longint unsigned len;
    vec_t r;
    len = int_sqrt(mag(v.x) * mag(v.x) + mag(v.y) * mag(v.y) + mag(v.z) * mag(v.z));
    if (len == 0) return v;
    r.x = unit_comp(v.x, len);
    r.y = unit_comp(v.y, len);
    r.z = unit_comp(v.z, len);
    return r;
  endfunction

  function automatic vec_t neg_vec(vec_t v);
    vec_t r;
    r.x = neg_q(v.x); r.y = neg_q(v.y); r.z = neg_q(v.z);
    return r;
  endfunction

  function automatic wide_t scale(q_t a, q_t b, int s);
    wide_t wa, wb;
    wa = a; wb = b;
    return (wa * wb) >>> s;
  endfunction

  task automatic expand_box(input logic [191:0] d);
    vec_t  p, dir, d1, d2, ex;
    vec_t  nrm [6];
    wide_t cx [8], cy [8], cz [8];
    wide_t ax, ay, az, bx, by, bz;
    int    s1, s2, c;
    vertex_t vt;
    p.x = d[31:0];     p.y = d[63:32];    p.z = d[95:64];
    dir.x = d[127:96]; dir.y = d[159:128]; dir.z = d[191:160];
    if (norm_en) dir = unit_vec(dir);
    ex.x = 32'sh10000; ex.y = 0; ex.z = 0;
    d1 = cross_q(dir, ex);
    d2 = cross_q(d1, dir);
    // d2 is formed from the raw d1, both normalized afterwards
    if (norm_en) begin
      d1 = unit_vec(d1);
      d2 = unit_vec(d2);
    end
    ax = scale(d1.x, half_w, 16); ay = scale(d1.y, half_w, 16); az = scale(d1.z, half_w, 16);
    bx = scale(d2.x, half_d, 16); by = scale(d2.y, half_d, 16); bz = scale(d2.z, half_d, 16);
    for (int k = 0; k < 4; k++) begin
      s1 = (k == 1 || k == 2) ? 1 : -1;
      s2 = (k >= 2) ? 1 : -1;
      cx[k] = wide_t'(p.x) + s1 * ax + s2 * bx;
      cy[k] = wide_t'(p.y) + s1 * ay + s2 * by;
      cz[k] = wide_t'(p.z) + s1 * az + s2 * bz;
      cx[k+4] = cx[k] + scale(dir.x, half_l, 15);
      cy[k+4] = cy[k] + scale(dir.y, half_l, 15);
      cz[k+4] = cz[k] + scale(dir.z, half_l, 15);
    end
    nrm[0] = neg_vec(dir); nrm[1] = dir; nrm[2] = neg_vec(d2);
    nrm[3] = d1;           nrm[4] = d2;  nrm[5] = neg_vec(d1);
    for (int y = 0; y < VERTS_PER_BOX; y++) begin
      c = CORNER_TAB[y];
      vt.px = sat_q(cx[c]); vt.py = sat_q(cy[c]); vt.pz = sat_q(cz[c]);
      vt.nx = nrm[y/4].x;   vt.ny = nrm[y/4].y;   vt.nz = nrm[y/4].z;
      vt.u = (y % 4 == 1) || (y % 4 == 2);
      vt.v = (y % 4 >= 2);
      vt.idx = 12'((box_num * VERTS_PER_BOX + y) & 'hfff);
      vt.last = (y == VERTS_PER_BOX - 1);
      vertex_q.push_back(vt);
    end
    box_num = (box_num + 1 >= BOXES_PER_BATCH) ? 0 : box_num + 1;
  endtask

  task automatic check_vertex();
    vertex_t w;
    if (vertex_q.size() == 0) begin
      report("unexpected vertex", m_tdata_i[31:0], 0);
      return;
    end
    w = vertex_q.pop_front();
    if (m_tdata_i[31:0] !== w.px) report("vert_x", m_tdata_i[31:0], w.px);
    if (m_tdata_i[63:32] !== w.py) report("vert_y", m_tdata_i[63:32], w.py);
    if (m_tdata_i[95:64] !== w.pz) report("vert_z", m_tdata_i[95:64], w.pz);
    if (m_tdata_i[127:96] !== w.nx) report("normal_x", m_tdata_i[127:96], w.nx);
    if (m_tdata_i[159:128] !== w.ny) report("normal_y", m_tdata_i[159:128], w.ny);
    if (m_tdata_i[191:160] !== w.nz) report("normal_z", m_tdata_i[191:160], w.nz);
    if (m_tdata_i[192] !== w.u) report("tex_u", m_tdata_i[192], w.u);
    if (m_tdata_i[193] !== w.v) report("tex_v", m_tdata_i[193], w.v);
    if (m_tdata_i[205:194] !== w.idx) report("vertex_index", m_tdata_i[205:194], w.idx);
    if (m_tlast_i !== w.last) report("last_vertex", m_tlast_i, w.last);
  endtask

  initial begin
    fail_count_o = 0;
    half_w = HALF_RESET; half_d = HALF_RESET; half_l = HALF_RESET;
    norm_en = 1'b0;
    box_num = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (obve_reg_e'(cfg_addr_i))
          REG_HALF_WIDTH:  half_w = cfg_wdata_i;
          REG_HALF_DEPTH:  half_d = cfg_wdata_i;
          REG_HALF_LENGTH: half_l = cfg_wdata_i;
          REG_NORM_EN:     norm_en = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_vertex();
      if (s_tvalid_i && s_tready_i) expand_box(s_tdata_i);
    end
  end

endmodule

[tb/sv/oriented_box_vertex_expander_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oriented_box_vertex_expander_unit_tb: box expander testbench
// Drives directed and random boxes under several register settings with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module oriented_box_vertex_expander_unit_tb;
  import obve_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic         clk_i, rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_addr_i;
  logic [31:0]  cfg_wdata_i;
  logic         s_axis_tvalid_i, s_axis_tready_o;
  logic [191:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o, m_axis_tready_i;
  logic [207:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  int           fail_count, pending;
  int           idle_cycles;
  int           vert_xfers;
  logic         no_idle;

  oriented_box_vertex_expander_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
  );

  obve_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_tvalid_i(s_axis_tvalid_i), .s_tready_i(s_axis_tready_o),
    .s_tdata_i(s_axis_tdata_i), .m_tvalid_i(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i), .m_tdata_i(m_axis_tdata_o),
    .m_tlast_i(m_axis_tlast_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_addr_i = '0; cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0; s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    no_idle = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random hold-offs, one long hold to back the block up
  initial begin
    int n;
    vert_xfers = 0;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 4);
      if (vert_xfers == 2400) n = 400;
      if (n > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      vert_xfers++;
    end
  end

  task automatic send_box(input logic [191:0] d);
    int n;
    n = no_idle ? 0 : $urandom_range(0, 4);
    if (n > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic write_reg(input obve_reg_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait first so the checker has queued the box just taken
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3, 4: return 32'($signed($urandom_range(0, 'h80000)) - 'sh40000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [191:0] pack_box(logic [31:0] cx, cy, cz, ax, ay, az);
    return {az, ay, ax, cz, cy, cx};
  endfunction

  task automatic send_directed();
    logic [31:0] mx, mn;
    mx = 32'h7fff_ffff; mn = 32'h8000_0000;
    send_box(pack_box(0, 0, 0, 0, 0, 0));                  // zero-length axis
    send_box(pack_box(0, 0, 0, 32'h10000, 0, 0));          // axis along x, d1 zero
    send_box(pack_box(32'h20000, 32'h30000, 32'h40000, 0, 32'h10000, 0));
    send_box(pack_box(0, 0, 0, 0, 0, 32'h10000));
    send_box(pack_box(mx, mx, mx, mx, mx, mx));
    send_box(pack_box(mn, mn, mn, mn, mn, mn));
    send_box(pack_box(mx, mn, mx, mn, mx, mn));
    send_box(pack_box(0, 0, 0, 0, mn, 0));                 // negation of -2^31
    send_box(pack_box(32'hffff_ffff, 1, 32'hffff_ffff, 1, 32'hffff_ffff, 1));
    send_box(pack_box(0, 0, 0, 32'h8000, 32'h8000, 32'h8000));
    send_box(pack_box(0, 0, 0, 0, 1, 0));
    send_box(pack_box(0, 0, 0, mx, 0, 0));
  endtask

  initial begin
    logic [31:0] hw, hd, hl;
    @(posedge rst_ni);
    @(posedge clk_i);
    send_directed();                                       // reset settings
    drain();
    write_reg(REG_HALF_WIDTH, 32'h7fff_ffff);
    write_reg(REG_HALF_DEPTH, 32'h8000_0000);
    write_reg(REG_HALF_LENGTH, 32'h7fff_ffff);
    write_reg(REG_NORM_EN, 32'h1);
    send_directed();
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin hw = 32'h8000_0000; hd = 32'h7fff_ffff; hl = 32'h8000_0000; end
        1: begin hw = 0; hd = 0; hl = 0; end
        default: begin hw = rand_q(); hd = rand_q(); hl = rand_q(); end
      endcase
      write_reg(REG_HALF_WIDTH, hw);
      write_reg(REG_HALF_DEPTH, hd);
      write_reg(REG_HALF_LENGTH, hl);
      write_reg(REG_NORM_EN, {$urandom} | 32'((ph % 2) ^ 1));
      if (ph == 6) write_reg(REG_NORM_EN, {$urandom} & ~32'h1);
      no_idle = (ph == 3);
      for (int i = 0; i < 68; i++)
        send_box(pack_box(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q()));
    end
    drain();
    repeat (700) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
